// File: design/ft12fb_pkg.sv
// FT1.2 frame builder package: payload structs, item and job codes, frame characters.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package ft12fb_pkg;

    localparam logic [7:0] START_FIXED  = 8'h10;
    localparam logic [7:0] START_VAR    = 8'h68;
    localparam logic [7:0] STOP_CHAR    = 8'h16;
    localparam logic [7:0] ACK_CHAR     = 8'hE5;
    localparam logic [7:0] MAX_DATA_LEN = 8'd252;
    localparam logic [7:0] LEN_OVERHEAD = 8'd3;
    localparam logic [7:0] FCB_RESET    = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // bytes produced by each job
    localparam logic [3:0] LEN_FIXED      = 4'd5;
    localparam logic [3:0] LEN_HEADER     = 4'd7;
    localparam logic [3:0] LEN_HEADER_END = 4'd9;
    localparam logic [3:0] LEN_DATA       = 4'd1;
    localparam logic [3:0] LEN_DATA_END   = 4'd3;
    localparam logic [3:0] LEN_ACK        = 4'd1;

    typedef enum logic [1:0] {
        KIND_FIXED  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ACK    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        OP_FIXED      = 3'd0,
        OP_HEADER     = 3'd1,
        OP_HEADER_END = 3'd2,
        OP_DATA       = 3'd3,
        OP_DATA_END   = 3'd4,
        OP_ACK        = 3'd5
    } op_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] address;
        logic [7:0] control;
        logic [7:0] control_info;
        logic [7:0] data_length;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } out_item_t;

    // one classified item waiting for the byte sequencer
    typedef struct packed {
        op_t        op;
        logic [7:0] ctl_byte;   // control with frame count bit merged
        logic [7:0] addr_byte;
        logic [7:0] info_byte;  // CI for headers, user byte for data
        logic [7:0] len_byte;   // L field
        logic [7:0] sum_byte;   // checksum, valid on jobs that close a frame
    } job_t;

endpackage

// File: design/ft12fb_front.sv
// FT1.2 frame builder front end: holds the FCB mask and frame state, classifies beats into jobs.
// Depends on ft12fb_pkg.
`timescale 1ns / 1ps

module ft12fb_front
    import ft12fb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       accept,
    input  in_item_t   item,
    output logic       push,
    output job_t       job
);

    logic [7:0] fcb_mask_reg, fcb_mask_next;
    logic       count_bit_reg, count_bit_next;
    logic [7:0] sum_acc_reg, sum_acc_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       frame_open_reg, frame_open_next;

    logic [7:0] merged_ctl;
    logic [7:0] len_clamped;
    logic [7:0] hdr_sum;
    logic [7:0] data_sum;
    logic [7:0] left_dec;

    assign merged_ctl  = item.control | (count_bit_reg ? fcb_mask_reg : 8'h00);
    assign len_clamped = (item.data_length > MAX_DATA_LEN) ? MAX_DATA_LEN : item.data_length;
    assign hdr_sum     = merged_ctl + item.address + item.control_info;
    assign data_sum    = sum_acc_reg + item.data_byte;
    assign left_dec    = bytes_left_reg - 8'd1;

    always_comb begin
        fcb_mask_next   = cfg_we ? cfg_wdata : fcb_mask_reg;
        count_bit_next  = count_bit_reg;
        sum_acc_next    = sum_acc_reg;
        bytes_left_next = bytes_left_reg;
        frame_open_next = frame_open_reg;
        push            = 1'b0;
        job.op          = OP_ACK;
        job.ctl_byte    = merged_ctl;
        job.addr_byte   = item.address;
        job.info_byte   = item.control_info;
        job.len_byte    = len_clamped + LEN_OVERHEAD;
        job.sum_byte    = merged_ctl + item.address;
        if (accept) begin
            unique case (kind_t'(item.kind))
                KIND_FIXED: begin
                    push            = 1'b1;
                    job.op          = OP_FIXED;
                    count_bit_next  = ~count_bit_reg;
                    frame_open_next = 1'b0;
                    bytes_left_next = 8'd0;
                end
                KIND_HEADER: begin
                    push           = 1'b1;
                    count_bit_next = ~count_bit_reg;
                    sum_acc_next   = hdr_sum;
                    job.sum_byte   = hdr_sum;
                    if (len_clamped == 8'd0) begin
                        job.op          = OP_HEADER_END;
                        frame_open_next = 1'b0;
                        bytes_left_next = 8'd0;
                    end else begin
                        job.op          = OP_HEADER;
                        frame_open_next = 1'b1;
                        bytes_left_next = len_clamped;
                    end
                end
                KIND_DATA: begin
                    job.info_byte = item.data_byte;
                    job.sum_byte  = data_sum;
                    if (!frame_open_reg || bytes_left_reg == 8'd0) begin
                        // stray user byte: dropped, frame marked closed
                        frame_open_next = 1'b0;
                    end else begin
                        push            = 1'b1;
                        sum_acc_next    = data_sum;
                        bytes_left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            job.op          = OP_DATA_END;
                            frame_open_next = 1'b0;
                        end else begin
                            job.op = OP_DATA;
                        end
                    end
                end
                KIND_ACK: begin
                    push   = 1'b1;
                    job.op = OP_ACK;
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcb_mask_reg   <= FCB_RESET;
            count_bit_reg  <= 1'b0;
            sum_acc_reg    <= 8'd0;
            bytes_left_reg <= 8'd0;
            frame_open_reg <= 1'b0;
        end else begin
            fcb_mask_reg   <= fcb_mask_next;
            count_bit_reg  <= count_bit_next;
            sum_acc_reg    <= sum_acc_next;
            bytes_left_reg <= bytes_left_next;
            frame_open_reg <= frame_open_next;
        end
    end

endmodule

// File: design/ft12fb_fifo.sv
// FT1.2 frame builder job queue: small register FIFO between front end and sequencer.
// Depends on ft12fb_pkg.
`timescale 1ns / 1ps

module ft12fb_fifo
    import ft12fb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job popped from empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

endmodule

// File: design/ft12fb_back.sv
// FT1.2 frame builder sequencer: walks each job byte by byte into the output register.
// Depends on ft12fb_pkg.
`timescale 1ns / 1ps

module ft12fb_back
    import ft12fb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  job_t      head_job,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [3:0]  idx_reg, idx_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;
    logic [3:0]  job_len;
    logic [7:0]  cur_byte;
    logic        job_done;
    logic        closes_frame;
    logic        advance;

    assign advance  = head_valid && (!m_valid_reg || m_ready);
    assign job_done = (idx_reg == job_len - 4'd1);
    assign pop      = advance && job_done;

    always_comb begin
        job_len      = LEN_ACK;
        closes_frame = 1'b0;
        cur_byte     = ACK_CHAR;
        unique case (head_job.op) inside
            OP_FIXED: begin
                job_len      = LEN_FIXED;
                closes_frame = 1'b1;
                case (idx_reg)
                    4'd0:    cur_byte = START_FIXED;
                    4'd1:    cur_byte = head_job.ctl_byte;
                    4'd2:    cur_byte = head_job.addr_byte;
                    4'd3:    cur_byte = head_job.sum_byte;
                    default: cur_byte = STOP_CHAR;
                endcase
            end
            OP_HEADER, OP_HEADER_END: begin
                job_len      = (head_job.op == OP_HEADER) ? LEN_HEADER : LEN_HEADER_END;
                closes_frame = (head_job.op == OP_HEADER_END);
                case (idx_reg)
                    4'd0:    cur_byte = START_VAR;
                    4'd1:    cur_byte = head_job.len_byte;
                    4'd2:    cur_byte = head_job.len_byte;
                    4'd3:    cur_byte = START_VAR;
                    4'd4:    cur_byte = head_job.ctl_byte;
                    4'd5:    cur_byte = head_job.addr_byte;
                    4'd6:    cur_byte = head_job.info_byte;
                    4'd7:    cur_byte = head_job.sum_byte;
                    default: cur_byte = STOP_CHAR;
                endcase
            end
            OP_DATA: begin
                job_len  = LEN_DATA;
                cur_byte = head_job.info_byte;
            end
            OP_DATA_END: begin
                job_len      = LEN_DATA_END;
                closes_frame = 1'b1;
                case (idx_reg)
                    4'd0:    cur_byte = head_job.info_byte;
                    4'd1:    cur_byte = head_job.sum_byte;
                    default: cur_byte = STOP_CHAR;
                endcase
            end
            OP_ACK: begin
                job_len      = LEN_ACK;
                closes_frame = 1'b1;
                cur_byte     = ACK_CHAR;
            end
            default: begin
                job_len = LEN_ACK;
            end
        endcase
    end

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (advance) begin
            idx_next              = job_done ? 4'd0 : idx_reg + 4'd1;
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = cur_byte;
            m_data_next.frame_end = job_done && closes_frame;
            m_data_next.run_last  = job_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.frame_end |-> m_data_reg.run_last)
        else $error("frame end on a beat that is not the last of its job");

    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> idx_reg == 4'd0)
        else $error("byte index left mid-job with no job queued");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg < job_len)
        else $error("byte index past end of job");

endmodule

// File: design/ft12_frame_builder.sv
// FT1.2 frame builder top level: front end, job queue and byte sequencer.
// Depends on ft12fb_pkg, ft12fb_front, ft12fb_fifo, ft12fb_back.
`timescale 1ns / 1ps

// Turns link-layer requests into the FT1.2 byte stream, one byte per output beat.
// A fixed-frame beat gives 10h C A CS 16h; a header beat gives 68h L L 68h C A CI
// (plus CS 16h when the length is zero, L = length + 3, length clamped to 252);
// each user-data beat gives its byte, the last one followed by CS and 16h; an ack
// beat gives E5h. C carries the frame count bit (fcb_mask) on alternate frames.
// Stray data beats with no frame open produce nothing. frame_end flags 16h/E5h,
// run_last flags the final byte of each input beat. An input beat is taken
// whenever the 4-deep job queue has room; the sequencer then emits one output
// byte per cycle while the receiver is ready, so data beats stream at one per
// cycle, and a header gives 7 or 9 bytes. The user must write fcb_mask through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce it.

module ft12_frame_builder
    import ft12fb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_head_valid;
    job_t q_head_job;
    logic in_accept;

    // front end never stalls on its own: only a full queue holds the input off
    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    ft12fb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (in_accept),
        .item      (s_data),
        .push      (q_push),
        .job       (q_push_job)
    );

    ft12fb_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    ft12fb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_job   (q_head_job),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: tb/ft12_frame_builder_tb.sv
// Self-checking testbench for ft12_frame_builder: directed and random link requests
// against a built-in FT1.2 byte-stream predictor. Depends on ft12fb_pkg and the RTL.
`timescale 1ns / 1ps

module ft12_frame_builder_tb;
    import ft12fb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000; // generous upper bound for the watchdog
    localparam int SETTLE_CYCLES = 16;     // queue depth plus pipeline, with margin
    localparam int RANDOM_BEATS  = 100;    // input beats that put bytes on the line
    localparam int HOLD_CYCLES   = 300;    // long receiver stall in the back-pressure test
    localparam int IDLE_PCT      = 32;
    localparam int MAX_REPORTS   = 40;

    // Everything driven into the block starts at a known value.
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_data;

    // Predictor state: a shadow of the frame builder's own bookkeeping.
    logic [7:0] fcb_mask_m = FCB_RESET;
    logic       fcb_bit    = 1'b0;  // frame count bit, toggles per fixed frame / header
    logic [7:0] run_sum    = 8'h00; // checksum of the open variable frame so far
    logic [7:0] data_left  = 8'h00; // user bytes still owed to the open frame
    logic       in_frame   = 1'b0;

    out_item_t exp_bytes[$];        // line bytes still to come, oldest first
    out_item_t want;
    int        errors          = 0;
    int        productive_beats = 0;
    int        cycles          = 0;
    int        sink_hold       = 0;  // cycles the receiver still has to hold off
    bit        src_idle_en     = 1'b1;
    bit        sink_idle_en    = 1'b1;

    ft12_frame_builder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d line bytes still outstanding", $time, exp_bytes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------

    function automatic out_item_t line_char(input logic [7:0] b, input logic is_end);
        out_item_t o;
        o.out_byte  = b;
        o.frame_end = is_end;
        o.run_last  = 1'b0;
        return o;
    endfunction

    // C field: control ORed with the mask on every other frame.
    function automatic logic [7:0] take_control(input logic [7:0] ctl);
        logic [7:0] c;
        c       = ctl | (fcb_bit ? fcb_mask_m : 8'h00);
        fcb_bit = ~fcb_bit;
        return c;
    endfunction

    // Appends the bytes one accepted beat puts on the line; returns how many.
    function automatic int predict_line_bytes(input in_item_t it);
        out_item_t  run[$];
        logic [7:0] c;
        logic [7:0] len;
        logic [7:0] lfield;
        case (it.kind)
            KIND_FIXED: begin
                // a fixed frame abandons any open variable frame
                in_frame  = 1'b0;
                data_left = 8'h00;
                c = take_control(it.control);
                run.push_back(line_char(START_FIXED, 1'b0));
                run.push_back(line_char(c, 1'b0));
                run.push_back(line_char(it.address, 1'b0));
                run.push_back(line_char(c + it.address, 1'b0));
                run.push_back(line_char(STOP_CHAR, 1'b1));
            end
            KIND_HEADER: begin
                len    = (it.data_length > MAX_DATA_LEN) ? MAX_DATA_LEN : it.data_length;
                lfield = len + LEN_OVERHEAD;
                c = take_control(it.control);
                run_sum = c + it.address + it.control_info;
                run.push_back(line_char(START_VAR, 1'b0));
                run.push_back(line_char(lfield, 1'b0));
                run.push_back(line_char(lfield, 1'b0));
                run.push_back(line_char(START_VAR, 1'b0));
                run.push_back(line_char(c, 1'b0));
                run.push_back(line_char(it.address, 1'b0));
                run.push_back(line_char(it.control_info, 1'b0));
                if (len == 8'h00) begin
                    // empty frame closes at once
                    run.push_back(line_char(run_sum, 1'b0));
                    run.push_back(line_char(STOP_CHAR, 1'b1));
                    in_frame  = 1'b0;
                    data_left = 8'h00;
                end else begin
                    in_frame  = 1'b1;
                    data_left = len;
                end
            end
            KIND_DATA: begin
                if (!in_frame || data_left == 8'h00) begin
                    in_frame = 1'b0;   // stray byte, dropped
                    return 0;
                end
                run_sum = run_sum + it.data_byte;
                run.push_back(line_char(it.data_byte, 1'b0));
                data_left = data_left - 8'd1;
                if (data_left == 8'h00) begin
                    run.push_back(line_char(run_sum, 1'b0));
                    run.push_back(line_char(STOP_CHAR, 1'b1));
                    in_frame = 1'b0;
                end
            end
            default: begin
                // ack leaves an open frame open
                run.push_back(line_char(ACK_CHAR, 1'b1));
            end
        endcase
        run[run.size() - 1].run_last = 1'b1;
        foreach (run[i]) exp_bytes.push_back(run[i]);
        return run.size();
    endfunction

    //------------------------------------------------------------------------
    // Result side: random stalls, optional long hold, and the byte checker
    //------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !sink_idle_en || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Each beat on the line is matched against the oldest predicted byte.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_bytes.size() == 0) begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none, got byte %h end %b last %b",
                             $time, m_data.out_byte, m_data.frame_end, m_data.run_last);
            end else begin
                want = exp_bytes.pop_front();
                if (m_data !== want) begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS) begin
                        if (m_data.out_byte !== want.out_byte)
                            $display("%0t: out_byte expected %h got %h",
                                     $time, want.out_byte, m_data.out_byte);
                        if (m_data.frame_end !== want.frame_end)
                            $display("%0t: frame_end expected %b got %b",
                                     $time, want.frame_end, m_data.frame_end);
                        if (m_data.run_last !== want.run_last)
                            $display("%0t: run_last expected %b got %b",
                                     $time, want.run_last, m_data.run_last);
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------------
    // Input side helpers
    //------------------------------------------------------------------------

    // Random content in every field, then the kind forced.
    function automatic in_item_t make_item(input kind_t k);
        in_item_t it;
        it.kind         = k;
        it.address      = 8'($urandom);
        it.control      = 8'($urandom);
        it.control_info = 8'($urandom);
        it.data_length  = 8'($urandom);
        it.data_byte    = 8'($urandom);
        return it;
    endfunction

    // Offers one beat (after optional random idle cycles) and waits for the handshake.
    // Returns in the step of acceptance with valid still high, so the next call can
    // keep it high back to back.
    task automatic send_item(input in_item_t it);
        while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (predict_line_bytes(it) > 0)
            productive_beats = productive_beats + 1;
    endtask

    // Sender pauses until every predicted byte has been seen.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (exp_bytes.size() != 0);
    endtask

    // Register writes only with the block idle; dropped data beats may still be
    // in flight when the last byte arrives, hence the settle time.
    task automatic set_fcb_mask(input logic [7:0] mask);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mask;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        fcb_mask_m = mask;
    endtask

    function automatic in_item_t header_item(input logic [7:0] len);
        in_item_t it;
        it = make_item(KIND_HEADER);
        it.data_length = len;
        return it;
    endfunction

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    // Fixed frames at the field extremes; checksum wraps on FF + FF.
    task automatic test_fixed_frames();
        in_item_t it;
        it = make_item(KIND_FIXED);
        it.address = 8'h00; it.control = 8'h00;
        send_item(it);
        it.address = 8'hFF; it.control = 8'hFF;
        send_item(it);
        it.address = 8'h80; it.control = 8'h7F;
        send_item(it);
    endtask

    // Variable frames: empty, short, clamped length, and one abandoned by a new header.
    task automatic test_variable_frames();
        in_item_t it;
        it = header_item(8'd0);
        it.address = 8'h00; it.control = 8'h00; it.control_info = 8'h00;
        send_item(it);
        it.address = 8'hFF; it.control = 8'hFF; it.control_info = 8'hFF;
        send_item(it);
        send_item(header_item(8'd2));
        it = make_item(KIND_DATA);
        it.data_byte = 8'h00;
        send_item(it);
        it.data_byte = 8'hFF;
        send_item(it);
        // length over the limit: L field must read FFh
        send_item(header_item(8'hFF));
        send_item(make_item(KIND_DATA));
        send_item(make_item(KIND_DATA));
        // new header drops the clamped frame without a trailer
        send_item(header_item(8'd1));
        send_item(make_item(KIND_DATA));
    endtask

    // Stray data, ack inside an open frame, and a fixed frame cutting one short.
    task automatic test_stray_and_abandon();
        send_item(make_item(KIND_DATA));   // nothing open: dropped
        send_item(header_item(8'd3));
        send_item(make_item(KIND_DATA));
        send_item(make_item(KIND_ACK));    // frame stays open
        send_item(make_item(KIND_DATA));
        send_item(make_item(KIND_FIXED));  // abandons the frame
        send_item(make_item(KIND_DATA));   // dropped
        send_item(make_item(KIND_ACK));
    endtask

    // fcb_mask at both extremes and a random value, then back to reset value.
    task automatic test_fcb_mask();
        logic [7:0] masks [4];
        masks[0] = 8'hFF;
        masks[1] = 8'h00;
        masks[2] = 8'($urandom);
        masks[3] = FCB_RESET;
        foreach (masks[i]) begin
            set_fcb_mask(masks[i]);
            send_item(make_item(KIND_FIXED));
            send_item(make_item(KIND_FIXED));
            send_item(header_item(8'd0));
            send_item(header_item(8'd1));
            send_item(make_item(KIND_DATA));
        end
    endtask

    // Receiver stalls for a long stretch while beats keep coming, so the job queue
    // fills and s_ready drops; then the sender waits for the line to drain.
    task automatic test_backpressure();
        src_idle_en = 1'b0;
        sink_hold   = HOLD_CYCLES;
        repeat (4) begin
            send_item(header_item(8'd0));
            send_item(make_item(KIND_FIXED));
            send_item(make_item(KIND_ACK));
        end
        wait_drained();
        src_idle_en = 1'b1;
    endtask

    // Mostly well-formed frames with random content; the rest is noise and frames
    // broken off early. A stretch in the middle runs with no idling on either side.
    task automatic test_random();
        in_item_t it;
        int       start;
        int       r;
        int       n;
        start = productive_beats;
        while (productive_beats - start < RANDOM_BEATS) begin
            src_idle_en  = !(productive_beats - start >= 40 && productive_beats - start < 75);
            sink_idle_en = src_idle_en;
            r = $urandom_range(99);
            if (r < 70) begin
                if ($urandom_range(9) == 0) begin
                    it = header_item(8'($urandom_range(253, 255)));
                    n  = $urandom_range(1, 5);        // clamped frame, never completed
                end else begin
                    it = header_item(8'($urandom_range(12)));
                    n  = int'(it.data_length);
                    if ($urandom_range(19) == 0)
                        n = n / 2;                    // broken off early
                end
                send_item(it);
                repeat (n) begin
                    if ($urandom_range(9) == 0)
                        send_item(make_item(KIND_ACK));
                    send_item(make_item(KIND_DATA));
                end
            end else if (r < 85) begin
                send_item(make_item(KIND_FIXED));
            end else if (r < 92) begin
                send_item(make_item(KIND_ACK));
            end else begin
                send_item(make_item(kind_t'($urandom_range(3))));
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    //------------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fixed_frames();
        test_variable_frames();
        test_stray_and_abandon();
        test_fcb_mask();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
